// ===== sv/apt_pkg.sv =====
package apt_pkg;

	// The group length is a power of two, so the group mean is a shift of the sum.
	localparam int AVG_SHIFT = 4;
	localparam int AVG_COUNT = 1 << AVG_SHIFT;

	localparam int CAP_W = 32;
	localparam int SUM_W = 40;
	localparam int SCNT_W = 9;
	localparam int FREQ_W = 40;
	localparam int CFG_IDX_W = 2;

	localparam logic [CAP_W-1:0] CLOCK_HZ_RESET = 32'd120000000;
	localparam logic [CAP_W-1:0] TIMEOUT_RESET = 32'd60000000;
	localparam logic [CAP_W-1:0] EDGE_RELOAD_RESET = 32'd120000000;

	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_RELOAD = 2'd2;

	localparam logic [1:0] REQ_EDGE = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam int QUO_W = 40;
	localparam int DVS_W = 32;
	localparam int DIV_CNT_W = $clog2(QUO_W);

	typedef struct packed {
		logic start;
		logic [QUO_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== sv/apt_divider.sv =====
module apt_divider import apt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [QUO_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     divisor_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W+1:0] trial;

	assign rem_sh = {rem_q, quo_q[QUO_W-1]};
	assign trial = {1'b0, rem_sh} - {2'b00, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			divisor_q <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q <= '0;
				quo_q <= req.dividend;
				rem_q <= '0;
				divisor_q <= req.divisor;
			end else if (busy_q) begin
				if (!trial[DVS_W+1]) begin
					rem_q <= trial[DVS_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DVS_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== sv/averaging_period_tachometer.sv =====
// Period tachometer with group averaging and a Q8 frequency output.
// The item channel (item_valid, item_stall) carries req_type and
// capture_value: an edge capture, a timer tick or a software clear.
// Every accepted item yields exactly one result on the result channel
// (result_valid, result_stall): alive, raw_period, average_period and
// frequency_q8 as they stand after the item.
// The three setup registers are written through cfg_we, cfg_index and
// cfg_data; an index above two is ignored. The user must write them only
// while the block is idle; the block itself does not enforce this. The
// 40-step restoring divider forms the frequency; the group mean is a shift
// of the sum. While the average is zero the divide is skipped. The next
// item can be taken in the cycle after the result is loaded; the block takes
// no new item before it is through with the last one.
// item_stall is high from acceptance until the result has been moved into
// the output register. When the receiver stalls, the result is held, the
// next item may still be taken and worked on, and it waits for the output
// register to free up.
// Reset clears all measurement state and the average, loads the countdown
// with the timeout value and restores the register defaults.
module averaging_period_tachometer import apt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [1:0]           req_type,
	input  logic [CAP_W-1:0]     capture_value,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 alive,
	output logic [CAP_W-1:0]     raw_period,
	output logic [CAP_W-1:0]     average_period,
	output logic [FREQ_W-1:0]    frequency_q8,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_ACC,
		S_AVG,
		S_FREQ,
		S_FREQ_W,
		S_OUT
	} state_t;

	localparam logic [SCNT_W-1:0] GROUP_LEN = SCNT_W'(AVG_COUNT);

	state_t state_q;

	logic [CAP_W-1:0] clock_hz_q;
	logic [CAP_W-1:0] timeout_q;
	logic [CAP_W-1:0] edge_reload_q;

	logic [1:0]        req_q;
	logic [CAP_W-1:0]  cap_q;
	logic [CAP_W-1:0]  period_q;
	logic [CAP_W-1:0]  prev_capture_q;
	logic [CAP_W-1:0]  last_period_q;
	logic [SUM_W-1:0]  period_sum_q;
	logic [SCNT_W-1:0] sample_count_q;
	logic [CAP_W-1:0]  mean_period_q;
	logic              alive_flag_q;
	logic [CAP_W-1:0]  countdown_q;
	logic [FREQ_W-1:0] freq_q;

	logic              res_valid_q;
	logic              res_alive_q;
	logic [CAP_W-1:0]  res_raw_q;
	logic [CAP_W-1:0]  res_avg_q;
	logic [FREQ_W-1:0] res_freq_q;

	logic              accept;
	logic              out_free;
	logic [SCNT_W-1:0] count_next;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign item_stall = (state_q != S_IDLE);
	assign accept = item_valid && !item_stall;
	assign out_free = !res_valid_q || !result_stall;
	assign count_next = sample_count_q + 1'b1;

	always_comb begin
		div_req.start = (state_q == S_FREQ) && (mean_period_q != '0);
		div_req.dividend = {clock_hz_q, 8'h00};
		div_req.divisor = mean_period_q;
	end

	apt_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clock_hz_q <= CLOCK_HZ_RESET;
			timeout_q <= TIMEOUT_RESET;
			edge_reload_q <= EDGE_RELOAD_RESET;
			req_q <= REQ_EDGE;
			cap_q <= '0;
			period_q <= '0;
			prev_capture_q <= '0;
			last_period_q <= '0;
			period_sum_q <= '0;
			sample_count_q <= '0;
			mean_period_q <= '0;
			alive_flag_q <= 1'b0;
			countdown_q <= TIMEOUT_RESET;
			freq_q <= '0;
			res_valid_q <= 1'b0;
			res_alive_q <= 1'b0;
			res_raw_q <= '0;
			res_avg_q <= '0;
			res_freq_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CLOCK_HZ: clock_hz_q <= cfg_data;
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_EDGE_RELOAD: edge_reload_q <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= req_type;
						cap_q <= capture_value;
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					case (req_q)
						REQ_EDGE: begin
							period_q <= (prev_capture_q > cap_q) ? (prev_capture_q - cap_q)
								: (cap_q - prev_capture_q);
							prev_capture_q <= cap_q;
							countdown_q <= edge_reload_q;
							state_q <= S_ACC;
						end
						REQ_TICK: begin
							if (countdown_q <= 32'd1) begin
								prev_capture_q <= '0;
								last_period_q <= '0;
								period_sum_q <= '0;
								sample_count_q <= '0;
								alive_flag_q <= 1'b0;
								countdown_q <= timeout_q;
							end else begin
								countdown_q <= countdown_q - 1'b1;
							end
							state_q <= S_FREQ;
						end
						REQ_CLEAR: begin
							prev_capture_q <= '0;
							last_period_q <= '0;
							period_sum_q <= '0;
							sample_count_q <= '0;
							alive_flag_q <= 1'b0;
							state_q <= S_FREQ;
						end
						default: state_q <= S_FREQ;
					endcase
				end
				S_ACC: begin
					if (period_q != '0) begin
						alive_flag_q <= 1'b1;
						last_period_q <= period_q;
						period_sum_q <= period_sum_q + SUM_W'(period_q);
						sample_count_q <= count_next;
						if (count_next >= GROUP_LEN) begin
							state_q <= S_AVG;
						end else begin
							state_q <= S_FREQ;
						end
					end else begin
						state_q <= S_FREQ;
					end
				end
				S_AVG: begin
					mean_period_q <= period_sum_q[AVG_SHIFT +: CAP_W];
					period_sum_q <= '0;
					sample_count_q <= '0;
					state_q <= S_FREQ;
				end
				S_FREQ: begin
					if (mean_period_q == '0) begin
						freq_q <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_FREQ_W;
					end
				end
				S_FREQ_W: begin
					if (div_rsp.done) begin
						freq_q <= div_rsp.quotient;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						res_alive_q <= alive_flag_q;
						res_raw_q <= last_period_q;
						res_avg_q <= mean_period_q;
						res_freq_q <= freq_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign alive = res_alive_q;
	assign raw_period = res_raw_q;
	assign average_period = res_avg_q;
	assign frequency_q8 = res_freq_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> item_stall)
		else $error("block took a second item before finishing the first");

	a_freq_needs_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && frequency_q8 != '0) |-> (average_period != '0))
		else $error("nonzero frequency reported with a zero average period");

	a_alive_has_period: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && alive) |-> (raw_period != '0))
		else $error("alive reported without a stored period");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while still working");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import apt_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int NUM_PHASES = 6;
	localparam int RANDOM_PER_PHASE = 165;
	localparam int SETTLE_CYCLES = 120;

	typedef struct packed {
		logic [1:0]       req;
		logic [CAP_W-1:0] cap;
	} tach_item_t;

	typedef struct packed {
		logic              alive;
		logic [CAP_W-1:0]  raw;
		logic [CAP_W-1:0]  avg;
		logic [FREQ_W-1:0] freq;
	} tach_reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic [1:0]           req_type = REQ_EDGE;
	logic [CAP_W-1:0]     capture_value = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic                 alive;
	logic [CAP_W-1:0]     raw_period;
	logic [CAP_W-1:0]     average_period;
	logic [FREQ_W-1:0]    frequency_q8;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CLOCK_HZ;
	logic [CAP_W-1:0]     cfg_data = '0;

	tach_item_t    pending_items[$];
	tach_reading_t expected_readings[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int items_queued = 0;
	int readings_checked = 0;
	int edges_seen = 0;
	int ticks_seen = 0;
	int clears_seen = 0;
	int unused_seen = 0;
	int groups_done = 0;
	int expiries = 0;
	int reg_writes = 0;

	// Predicted block state and register copies.
	logic [CAP_W-1:0]  hz_setting = CLOCK_HZ_RESET;
	logic [CAP_W-1:0]  timeout_setting = TIMEOUT_RESET;
	logic [CAP_W-1:0]  reload_setting = EDGE_RELOAD_RESET;
	logic [CAP_W-1:0]  last_capture = '0;
	logic [CAP_W-1:0]  held_period = '0;
	logic [CAP_W-1:0]  group_mean = '0;
	logic [CAP_W-1:0]  ticks_left = TIMEOUT_RESET;
	logic [SUM_W-1:0]  group_sum = '0;
	logic [SCNT_W-1:0] group_count = '0;
	logic              is_alive = 1'b0;

	logic [CAP_W-1:0]  gen_capture = '0;

	always #4 clk = ~clk;

	averaging_period_tachometer uut (.*);

	function automatic void drop_measurement();
		last_capture = '0;
		held_period = '0;
		group_sum = '0;
		group_count = '0;
		is_alive = 1'b0;
	endfunction

	function automatic void predict_reading(input logic [1:0] req, input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] period;
		tach_reading_t r;
		case (req)
			REQ_EDGE: begin
				edges_seen++;
				period = (last_capture > cap) ? last_capture - cap : cap - last_capture;
				last_capture = cap;
				if (period != '0) begin
					is_alive = 1'b1;
					held_period = period;
					group_sum = group_sum + SUM_W'(period);
					group_count = group_count + 1'b1;
					if (group_count >= AVG_COUNT) begin
						group_mean = CAP_W'(group_sum / SUM_W'(group_count));
						group_sum = '0;
						group_count = '0;
						groups_done++;
					end
				end
				ticks_left = reload_setting;
			end
			REQ_TICK: begin
				ticks_seen++;
				if (ticks_left <= 1) begin
					drop_measurement();
					ticks_left = timeout_setting;
					expiries++;
				end else begin
					ticks_left = ticks_left - 1'b1;
				end
			end
			REQ_CLEAR: begin
				clears_seen++;
				drop_measurement();
			end
			default: begin
				unused_seen++;
			end
		endcase
		r.alive = is_alive;
		r.raw = held_period;
		r.avg = group_mean;
		r.freq = (group_mean == '0) ? '0 : {hz_setting, 8'h00} / {8'h00, group_mean};
		expected_readings.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input logic [FREQ_W-1:0] got,
			input logic [FREQ_W-1:0] want);
		errors++;
		$display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		tach_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (item_valid)
				predict_reading(req_type, capture_value);
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_items.pop_front();
				item_valid <= 1'b1;
				req_type <= nxt.req;
				capture_value <= nxt.cap;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		tach_reading_t want;
		if (arst_n) begin
			result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			if (result_valid && !result_stall) begin
				if (expected_readings.size() == 0) begin
					report_mismatch("unexpected result, raw_period", raw_period, '0);
				end else begin
					want = expected_readings.pop_front();
					readings_checked++;
					if (alive !== want.alive)
						report_mismatch("alive", alive, want.alive);
					if (raw_period !== want.raw)
						report_mismatch("raw_period", raw_period, want.raw);
					if (average_period !== want.avg)
						report_mismatch("average_period", average_period, want.avg);
					if (frequency_q8 !== want.freq)
						report_mismatch("frequency_q8", frequency_q8, want.freq);
				end
			end
		end
	end

	function automatic void queue_item(input logic [1:0] req, input logic [CAP_W-1:0] cap);
		tach_item_t it;
		it.req = req;
		it.cap = cap;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	task automatic wait_until_idle();
		@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_readings.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CLOCK_HZ: hz_setting = val;
			REG_TIMEOUT: timeout_setting = val;
			REG_EDGE_RELOAD: reload_setting = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic configure_phase(input int ph);
		case (ph)
			0: begin
				write_reg(REG_CLOCK_HZ, 32'hFFFF_FFFF);
				write_reg(REG_TIMEOUT, 32'd1);
				write_reg(REG_EDGE_RELOAD, 32'd2);
			end
			1: begin
				write_reg(REG_CLOCK_HZ, 32'd1);
				write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
				write_reg(REG_EDGE_RELOAD, 32'hFFFF_FFFF);
			end
			2: begin
				write_reg(REG_CLOCK_HZ, $urandom_range(1, 32'hFFFF_FFFF));
				write_reg(REG_TIMEOUT, $urandom_range(1, 40));
				write_reg(REG_EDGE_RELOAD, $urandom_range(1, 60));
			end
			3: begin
				write_reg(REG_CLOCK_HZ, CLOCK_HZ_RESET);
				write_reg(REG_TIMEOUT, TIMEOUT_RESET);
				write_reg(REG_EDGE_RELOAD, EDGE_RELOAD_RESET);
				write_reg(REG_UNUSED, $urandom);
			end
			4: begin
				write_reg(REG_CLOCK_HZ, $urandom_range(1, 32'hFFFF_FFFF));
				write_reg(REG_TIMEOUT, $urandom_range(1, 2000));
				write_reg(REG_EDGE_RELOAD, $urandom_range(1, 3000));
			end
			default: begin
				write_reg(REG_CLOCK_HZ, $urandom_range(1, 1000));
				write_reg(REG_TIMEOUT, $urandom_range(1, 8));
				write_reg(REG_EDGE_RELOAD, $urandom_range(1, 8));
			end
		endcase
	endtask

	task automatic queue_directed();
		queue_item(REQ_TICK, 32'hFFFF_FFFF);
		queue_item(REQ_EDGE, '0);
		queue_item(REQ_EDGE, '1);
		queue_item(REQ_EDGE, '0);
		queue_item(REQ_UNUSED, 32'h5A5A_A5A5);
		repeat (3) queue_item(REQ_TICK, '0);
		queue_item(REQ_EDGE, 32'd5);
		queue_item(REQ_CLEAR, '1);
		queue_item(REQ_EDGE, 32'd5);
		// Alternate between the capture extremes so the group mean comes close to the
		// largest period.
		for (int k = 0; k < AVG_COUNT - 1; k++)
			queue_item(REQ_EDGE, k[0] ? '0 : '1);
		gen_capture = '1;
	endtask

	// Mostly full groups of edges with random periods, the rest loose requests.
	task automatic queue_random(input int n);
		int target;
		int run;
		int mode;
		logic [CAP_W-1:0] step;
		target = items_queued + n;
		while (items_queued < target) begin
			if ($urandom_range(0, 9) < 7) begin
				run = AVG_COUNT + $urandom_range(0, 5);
				mode = $urandom_range(0, 3);
				for (int k = 0; k < run; k++) begin
					if ($urandom_range(0, 11) == 0)
						queue_item(REQ_TICK, $urandom);
					case (mode)
						0: step = 32'd1;
						1: step = $urandom_range(1, 5000);
						2: step = $urandom;
						default: step = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(1, 300);
					endcase
					if ($urandom_range(0, 15) == 0)
						step = '0;
					gen_capture = ($urandom_range(0, 1) != 0) ? gen_capture + step : gen_capture - step;
					queue_item(REQ_EDGE, gen_capture);
				end
			end else begin
				repeat ($urandom_range(1, 6))
					queue_item(2'($urandom_range(0, 3)), $urandom);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_until_idle();
			if (ph < 2) begin
				send_idle_pct = 31;
				recv_stall_pct = 71;
			end else if (ph < 4) begin
				send_idle_pct = 71;
				recv_stall_pct = 31;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			configure_phase(ph);
			if (ph == 0)
				queue_directed();
			queue_random(RANDOM_PER_PHASE);
		end
		wait_until_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Checked %0d results from %0d edges, %0d ticks, %0d clears, %0d unused requests.",
			readings_checked, edges_seen, ticks_seen, clears_seen, unused_seen);
		$display("%0d averaging groups, %0d timeout expiries, %0d register writes over %0d phases.",
			groups_done, expiries, reg_writes, NUM_PHASES);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches.", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("Timed out with %0d items pending and %0d results outstanding.",
			pending_items.size(), expected_readings.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
